>>> rtl/core/ssbd_pkg.sv
package ssbd_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int TDATA_W   = PIX_W * NUM_CH;
  localparam int FACTOR_W  = 4;
  localparam int WIDTH_W   = 13;
  localparam int CFG_W     = WIDTH_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR    = 1'b0,
    REG_OUT_WIDTH = 1'b1
  } reg_idx_e;

  // where one word sits inside its block and face
  typedef struct packed {
    logic fresh;  // top-left of a block: load instead of accumulate
    logic done;   // bottom-right of a block: average is ready
    logic last;   // final block of the face
  } pos_t;

endpackage

>>> rtl/core/ssbd_ctrl.sv
module ssbd_ctrl #(
  parameter int MAX_OUT_WIDTH = 4096,
  parameter int MAX_FACTOR    = 8,
  parameter int AW            = 12,
  parameter int DW            = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ssbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssbd_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                step_i,
  output logic [AW-1:0]                       addr_o,
  output ssbd_pkg::pos_t                      pos_o,
  output logic [DW-1:0]                       fsq_o
);

  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int WW = $clog2(MAX_OUT_WIDTH + 1);

  logic [ssbd_pkg::FACTOR_W-1:0] factor_q;
  logic [ssbd_pkg::WIDTH_W-1:0]  width_q;
  logic [DW-1:0]                 fsq_q, fsq_d;
  logic [FW-1:0]                 f_eff, f_m1;
  logic [WW-1:0]                 w_eff, w_m1;
  logic [FW-1:0]                 sub_c_q, sub_c_d, sub_r_q, sub_r_d;
  logic [WW-1:0]                 ocol_q, ocol_d, orow_q, orow_d;
  logic                          col_end, row_end, line_end;

  // out-of-range settings are clamped
  always_comb begin
    if (factor_q == '0) begin
      f_eff = FW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(factor_q);
    end
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_OUT_WIDTH) begin
      w_eff = WW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
  end

  assign f_m1     = f_eff - FW'(1);
  assign w_m1     = w_eff - WW'(1);
  assign fsq_d    = DW'(f_eff) * DW'(f_eff);
  assign col_end  = (sub_c_q == f_m1);
  assign row_end  = (sub_r_q == f_m1);
  assign line_end = col_end && (ocol_q == w_m1);

  always_comb begin
    sub_c_d = sub_c_q;
    sub_r_d = sub_r_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    if (cfg_we_i) begin
      sub_c_d = '0;
      sub_r_d = '0;
      ocol_d  = '0;
      orow_d  = '0;
    end else if (step_i) begin
      if (!col_end) begin
        sub_c_d = sub_c_q + FW'(1);
      end else begin
        sub_c_d = '0;
        if (!line_end) begin
          ocol_d = ocol_q + WW'(1);
        end else begin
          ocol_d = '0;
          if (!row_end) begin
            sub_r_d = sub_r_q + FW'(1);
          end else begin
            sub_r_d = '0;
            orow_d  = (orow_q == w_m1) ? '0 : orow_q + WW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= ssbd_pkg::FACTOR_RST;
      width_q  <= ssbd_pkg::WIDTH_RST;
      fsq_q    <= DW'(1);
      sub_c_q  <= '0;
      sub_r_q  <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (ssbd_pkg::reg_idx_e'(cfg_idx_i))
          ssbd_pkg::REG_FACTOR:    factor_q <= cfg_data_i[ssbd_pkg::FACTOR_W-1:0];
          ssbd_pkg::REG_OUT_WIDTH: width_q  <= cfg_data_i[ssbd_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      fsq_q   <= fsq_d;
      sub_c_q <= sub_c_d;
      sub_r_q <= sub_r_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
    end
  end

  assign addr_o      = ocol_q[AW-1:0];
  assign pos_o.fresh = (sub_c_q == '0) && (sub_r_q == '0);
  assign pos_o.done  = col_end && row_end;
  assign pos_o.last  = line_end && row_end && (orow_q == w_m1);
  assign fsq_o       = fsq_q;

endmodule

>>> rtl/core/ssbd_colmem.sv
module ssbd_colmem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int SW    = 14
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        acc_i,
  input  logic [AW-1:0]                               addr_i,
  input  ssbd_pkg::pos_t                              pos_i,
  input  logic [ssbd_pkg::TDATA_W-1:0]                pix_i,
  input  logic                                        adv_i,
  output logic                                        valid_o,
  output ssbd_pkg::pos_t                              pos_o,
  output logic [ssbd_pkg::NUM_CH-1:0][SW-1:0]         sum_o
);

  localparam int MW = ssbd_pkg::NUM_CH * SW;

  logic [MW-1:0] mem [DEPTH];

  logic                                       s1_valid_q;
  logic [AW-1:0]                              s1_addr_q;
  ssbd_pkg::pos_t                             s1_pos_q;
  logic [ssbd_pkg::TDATA_W-1:0]               s1_pix_q;
  logic [MW-1:0]                              rd_q;
  logic                                       lw_valid_q;
  logic [AW-1:0]                              lw_addr_q;
  logic [MW-1:0]                              lw_data_q;
  logic [MW-1:0]                              base;
  logic [ssbd_pkg::NUM_CH-1:0][SW-1:0]        sum;
  logic                                       wr;

  // the write of the previous word may land on the edge this word was read
  assign base = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : rd_q;
  assign wr   = s1_valid_q && adv_i;

  always_comb begin
    for (int ch = 0; ch < ssbd_pkg::NUM_CH; ch++) begin
      if (s1_pos_q.fresh) begin
        sum[ch] = SW'(s1_pix_q[ch*ssbd_pkg::PIX_W +: ssbd_pkg::PIX_W]);
      end else begin
        sum[ch] = base[ch*SW +: SW]
                + SW'(s1_pix_q[ch*ssbd_pkg::PIX_W +: ssbd_pkg::PIX_W]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[s1_addr_q] <= sum;
    end
    if (acc_i) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_addr_q <= addr_i;
      s1_pos_q  <= pos_i;
      s1_pix_q  <= pix_i;
    end
    if (wr) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
      if (wr) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  assign valid_o = s1_valid_q;
  assign pos_o   = s1_pos_q;
  assign sum_o   = sum;

endmodule

>>> rtl/core/ssbd_div.sv
module ssbd_div #(
  parameter int SW         = 14,
  parameter int DW         = 8,
  parameter int MAX_FACTOR = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  logic [ssbd_pkg::NUM_CH-1:0][SW-1:0]         sum_i,
  input  logic                                        last_i,
  input  logic [DW-1:0]                               fsq_i,
  input  logic                                        out_ready_i,
  output logic                                        free_o,
  output logic                                        out_valid_o,
  output logic [ssbd_pkg::TDATA_W-1:0]                out_data_o,
  output logic                                        out_last_o
);

  localparam int K  = SW + DW;
  localparam int RW = K + 1;
  localparam int PW = SW + RW;

  logic                                             s2_valid_q;
  logic [ssbd_pkg::NUM_CH-1:0][SW-1:0]              s2_sum_q;
  logic                                             s2_last_q;
  logic                                             out_valid_q;
  logic [ssbd_pkg::TDATA_W-1:0]                     out_data_q;
  logic                                             out_last_q;
  logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::PIX_W-1:0] quot;
  logic [ssbd_pkg::NUM_CH-1:0][PW-1:0]              prod;
  logic [RW-1:0]                                    recip;
  logic                                             out_free, s2_adv;

  // ceil(2^K / d), exact for every block sum below 2^SW and divisor below 2^DW
  function automatic logic [RW-1:0] recip_of(input int d);
    return RW'(((64'd1 << K) + 64'(d) - 64'd1) / 64'(d));
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_adv   = s2_valid_q && out_free;
  assign free_o   = !s2_valid_q || out_free;

  // small constant table, one entry per block size
  always_comb begin
    recip = '0;
    for (int f = 1; f <= MAX_FACTOR; f++) begin
      if (fsq_i == DW'(f * f)) begin
        recip = recip_of(f * f);
      end
    end
  end

  // reciprocal multiply; the average fits in a pixel
  always_comb begin
    for (int ch = 0; ch < ssbd_pkg::NUM_CH; ch++) begin
      prod[ch] = PW'(s2_sum_q[ch]) * PW'(recip);
      quot[ch] = prod[ch][K +: ssbd_pkg::PIX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s2_sum_q  <= sum_i;
      s2_last_q <= last_i;
    end
    if (s2_adv) begin
      out_data_q <= quot;
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/core/supersample_box_downsample_core.sv
// channel   dir  payload                                  handshake
// s_axis    in   tdata: pixel_blue, pixel_green, pixel_red tvalid/tready
// m_axis    out  tdata: avg_blue, avg_green, avg_red;      tvalid/tready
//                tlast: face_done
// cfg       in   cfg_idx_i, cfg_data_i                      cfg_we_i
//
// one word per cycle unless the input stalls; a block average leaves once its
// bottom-right word has passed the column store read, divide stage and output register
// the column store is read as a word is accepted and written back as that word leaves,
// with a bypass from the last write for consecutive words in the same column
// reset clears counters, handshakes and settings only; the store needs no clearing pass
// input stalls only while a finished block cannot move towards the output
module supersample_box_downsample_core #(
  parameter int MAX_OUT_WIDTH = 4096,
  parameter int MAX_FACTOR    = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ssbd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssbd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ssbd_pkg::TDATA_W-1:0]         s_axis_tdata,  // blue, green, red
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ssbd_pkg::TDATA_W-1:0]         m_axis_tdata,  // blue, green, red
  output logic                                 m_axis_tlast   // face_done
);

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int DW = 2 * FW;
  localparam int SW = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);

  logic                                 acc;
  logic [AW-1:0]                        addr;
  ssbd_pkg::pos_t                       pos, s1_pos;
  logic [DW-1:0]                        fsq;
  logic                                 s1_valid, s1_adv, s2_free;
  logic [ssbd_pkg::NUM_CH-1:0][SW-1:0]  sum;

  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_valid && (!s1_pos.done || s2_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  ssbd_ctrl #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_FACTOR    (MAX_FACTOR),
    .AW            (AW),
    .DW            (DW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (acc),
    .addr_o     (addr),
    .pos_o      (pos),
    .fsq_o      (fsq)
  );

  ssbd_colmem #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (AW),
    .SW    (SW)
  ) u_colmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .addr_i  (addr),
    .pos_i   (pos),
    .pix_i   (s_axis_tdata),
    .adv_i   (s1_adv),
    .valid_o (s1_valid),
    .pos_o   (s1_pos),
    .sum_o   (sum)
  );

  ssbd_div #(
    .SW         (SW),
    .DW         (DW),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && s1_pos.done),
    .sum_i       (sum),
    .last_i      (s1_pos.last),
    .fsq_i       (fsq),
    .out_ready_i (m_axis_tready),
    .free_o      (s2_free),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> test/ssbd_checker.sv
module ssbd_checker #(
  parameter int MAX_OUT_W = 4096,
  parameter int MAX_F     = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssbd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [ssbd_pkg::TDATA_W-1:0]   s_tdata_i,   // blue, green, red
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [ssbd_pkg::TDATA_W-1:0]   m_tdata_i,   // blue, green, red
  input  logic                           m_tlast_i,   // face_done
  output int                             mismatches_o,
  output int                             waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       face_done;
  } avg_px_t;

  logic [ssbd_pkg::FACTOR_W-1:0] factor_q;
  logic [ssbd_pkg::WIDTH_W-1:0]  width_q;
  logic [13:0]                   chan_sum [MAX_OUT_W][3];
  int                            in_col;
  int                            in_row;
  avg_px_t                       block_avgs [$];

  task automatic report(input string what, input int got, input int want);
    if (mismatches_o < 30)
      $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  // one supersampled word into the column store, maybe one block average out
  task automatic accumulate_pixel(input logic [ssbd_pkg::TDATA_W-1:0] word);
    int      f;
    int      w;
    int      face;
    int      ocol;
    int      sub_c;
    int      sub_r;
    int      divisor;
    avg_px_t avg;
    f = (factor_q == 0) ? 1 : (int'(factor_q) > MAX_F) ? MAX_F : int'(factor_q);
    w = (width_q == 0) ? 1 : (int'(width_q) > MAX_OUT_W) ? MAX_OUT_W : int'(width_q);
    face = w * f;
    if (in_col >= face) in_col = 0;
    if (in_row >= face) in_row = 0;
    ocol  = in_col / f;
    sub_c = in_col % f;
    sub_r = in_row % f;
    if (ocol >= MAX_OUT_W) ocol = MAX_OUT_W - 1;
    for (int ch = 0; ch < 3; ch++) begin
      if (sub_c == 0 && sub_r == 0)
        chan_sum[ocol][ch] = 14'(word[8*ch +: 8]);
      else
        chan_sum[ocol][ch] = chan_sum[ocol][ch] + 14'(word[8*ch +: 8]);
    end
    if (sub_c == f - 1 && sub_r == f - 1) begin
      divisor = f * f;
      avg.blue      = 8'(int'(chan_sum[ocol][0]) / divisor);
      avg.green     = 8'(int'(chan_sum[ocol][1]) / divisor);
      avg.red       = 8'(int'(chan_sum[ocol][2]) / divisor);
      avg.face_done = (in_col == face - 1) && (in_row == face - 1);
      block_avgs.push_back(avg);
    end
    if (in_col >= face - 1) begin
      in_col = 0;
      in_row = (in_row >= face - 1) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
  endtask

  task automatic check_avg(input logic [ssbd_pkg::TDATA_W-1:0] word, input logic last);
    avg_px_t want;
    if (block_avgs.size() == 0) begin
      report("word with nothing expected", int'(word), 0);
    end else begin
      want = block_avgs.pop_front();
      if (word[7:0] !== want.blue)    report("avg_blue", int'(word[7:0]), int'(want.blue));
      if (word[15:8] !== want.green)  report("avg_green", int'(word[15:8]), int'(want.green));
      if (word[23:16] !== want.red)   report("avg_red", int'(word[23:16]), int'(want.red));
      if (last !== want.face_done)    report("face_done", int'(last), int'(want.face_done));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     = ssbd_pkg::FACTOR_RST;
      width_q      = ssbd_pkg::WIDTH_RST;
      in_col       = 0;
      in_row       = 0;
      mismatches_o = 0;
      waiting_o    = 0;
      block_avgs.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ssbd_pkg::REG_FACTOR)
          factor_q = cfg_data_i[ssbd_pkg::FACTOR_W-1:0];
        else if (cfg_idx_i == ssbd_pkg::REG_OUT_WIDTH)
          width_q = cfg_data_i;
        // any register write restarts the face
        in_col = 0;
        in_row = 0;
      end
      if (s_tvalid_i && s_tready_i) accumulate_pixel(s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_avg(m_tdata_i, m_tlast_i);
      waiting_o = block_avgs.size();
    end
  end

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_W       = 4096;
  localparam int MAX_F       = 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [ssbd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ssbd_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ssbd_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ssbd_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                           m_axis_tlast;
  int                             mismatches;
  int                             waiting;
  int                             cycle_count = 0;
  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;

  supersample_box_downsample_core #(
    .MAX_OUT_WIDTH(MAX_W),
    .MAX_FACTOR   (MAX_F)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  ssbd_checker #(
    .MAX_OUT_W(MAX_W),
    .MAX_F    (MAX_F)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .mismatches_o(mismatches),
    .waiting_o   (waiting)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("supersample_box_downsample_core: mismatch");
      $finish;
    end
  end

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [23:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold off until every block average is out and the pipeline has emptied
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] f_val, input logic [12:0] w_val);
    logic [12:0] f_word;
    f_word = {9'($urandom), f_val};
    cfg_we <= 1'b1;
    if ($urandom_range(1) == 0) begin
      cfg_idx  <= ssbd_pkg::REG_FACTOR;
      cfg_data <= f_word;
      @(posedge clk);
      cfg_idx  <= ssbd_pkg::REG_OUT_WIDTH;
      cfg_data <= w_val;
    end else begin
      cfg_idx  <= ssbd_pkg::REG_OUT_WIDTH;
      cfg_data <= w_val;
      @(posedge clk);
      cfg_idx  <= ssbd_pkg::REG_FACTOR;
      cfg_data <= f_word;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [3:0] f_val, input logic [12:0] w_val,
                           input int count, input bit saturate);
    settle();
    configure(f_val, w_val);
    for (int i = 0; i < count; i++)
      send_pixel((saturate && $urandom_range(9) != 0) ? 24'hFFFFFF : random_pixel());
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic run_random_phase(output int count);
    int f_reg;
    int w_reg;
    int f;
    int w;
    int face;
    f_reg = $urandom_range(15);
    w_reg = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(6);
    f = (f_reg == 0) ? 1 : (f_reg > MAX_F) ? MAX_F : f_reg;
    w = (w_reg == 0) ? 1 : (w_reg > MAX_W) ? MAX_W : w_reg;
    face = f * w;
    if (face > 40)
      count = $urandom_range(20, 150);
    else
      count = face * face * $urandom_range(1, 2) + $urandom_range(0, face * face / 2);
    if (count > 250) count = 250;
    run_phase(4'(f_reg), 13'(w_reg), count, $urandom_range(3) == 0);
  endtask

  initial begin
    int n;
    int mode_items;
    send_idle_pct = 22;
    recv_idle_pct = 70;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every word is its own block
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hAAAAAA);
    send_pixel(24'h555555);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h123456);
    s_axis_tvalid <= 1'b0;

    // 2x2 faces of one block each: full-scale block, then a sum that rounds down
    settle();
    configure(4'd2, 13'd1);
    repeat (4) send_pixel(24'hFFFFFF);
    repeat (3) send_pixel(24'h010101);
    send_pixel(24'h000000);
    s_axis_tvalid <= 1'b0;

    // clamping of both registers and the widest face
    run_phase(4'd0, 13'd3, 86, 1'b0);
    run_phase(4'd8, 13'd1, 128, 1'b1);
    run_phase(4'd15, 13'd2, 256, 1'b0);
    run_phase(4'd9, 13'd0, 64, 1'b1);
    run_phase(4'd1, 13'd4096, 300, 1'b0);
    run_phase(4'd3, 13'd8191, 120, 1'b0);
    run_phase(4'd4, 13'd4097, 100, 1'b0);
    run_phase(4'd8, 13'd4096, 80, 1'b0);

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 22 : (m == 1) ? 70 : 0;
      recv_idle_pct = (m == 0) ? 70 : (m == 1) ? 22 : 0;
      mode_items = 0;
      while (mode_items < 250) begin
        run_random_phase(n);
        mode_items += n;
      end
    end

    settle();
    if (mismatches == 0)
      $display("supersample_box_downsample_core: match");
    else
      $display("supersample_box_downsample_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ssbd_pkg.sv
rtl/core/ssbd_ctrl.sv
rtl/core/ssbd_colmem.sv
rtl/core/ssbd_div.sv
rtl/core/supersample_box_downsample_core.sv
test/ssbd_checker.sv
test/tb.sv
